FILE: sv/udp_socket_demux_table_unit_defines.svh
`ifndef UDP_SOCKET_DEMUX_TABLE_UNIT_DEFINES_SVH
`define UDP_SOCKET_DEMUX_TABLE_UNIT_DEFINES_SVH

// Property that holds whenever the design is out of reset.
`define UDST_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define UDST_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define UDST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/udst_pkg.sv
`default_nettype none

package udst_pkg;

    localparam int SLOTS_DEFAULT = 64;
    localparam int SLOT_W        = 6;

    localparam logic [15:0] HDR_BYTES       = 16'd8;
    localparam logic [15:0] FIRST_EPHEMERAL = 16'd1024;

    localparam logic [1:0] MODE_RECEIVE    = 2'd0;
    localparam logic [1:0] MODE_CONNECT    = 2'd1;
    localparam logic [1:0] MODE_LISTEN     = 2'd2;
    localparam logic [1:0] MODE_DISCONNECT = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NOMATCH = 3'd1;
    localparam logic [2:0] ST_SHORT   = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_BADSLOT = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DISC_WR
    } state_t;

    // One table entry, ports and addresses in wire order.
    typedef struct packed {
        logic [15:0] local_port;
        logic [31:0] local_ip;
        logic [15:0] remote_port;
        logic [31:0] remote_ip;
        logic        listening;
    } entry_t;

    typedef struct packed {
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } key_t;

    typedef struct packed {
        logic listen_hit;
        logic full_hit;
    } match_t;

    function automatic logic [15:0] swap16(input logic [15:0] v);
        logic [15:0] r;
        r = {v[7:0], v[15:8]};
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: sv/udst_entry_ram.sv
`default_nettype none

module udst_entry_ram #(
    parameter int SLOTS = udst_pkg::SLOTS_DEFAULT
) (
    input  wire logic                                    clk,
    input  wire logic                                    wr_en,
    input  wire logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] wr_addr,
    input  wire udst_pkg::entry_t                        wr_data,
    input  wire logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] rd_addr,
    input  wire udst_pkg::key_t                          key,
    output udst_pkg::entry_t                             rd_data,
    output udst_pkg::match_t                             match
);
    import udst_pkg::*;

    entry_t mem [SLOTS];
    entry_t rd_data_reg;
    logic   local_hit;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        local_hit = (rd_data_reg.local_port == key.dst_port) &&
                    (rd_data_reg.local_ip == key.dst_ip);
        match.listen_hit = local_hit && rd_data_reg.listening;
        match.full_hit   = local_hit && (rd_data_reg.remote_port == key.src_port) &&
                           (rd_data_reg.remote_ip == key.src_ip);
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: sv/udp_socket_demux_table_unit.sv
// Channel   Handshake                 Payload
// input     start / busy              mode, src_ip, dst_ip, src_port, dst_port,
//                                     ip_payload_length, peer_ip, service_port,
//                                     slot_index
// result    done (one-cycle strobe)   status, slot, local_port_wire,
//                                     data_length, moved_from
// config    cfg_valid / cfg_ready     cfg_data (local_ip)
//
// Connect, listen, a short datagram and every rejected command finish without
// leaving S_IDLE; done follows on the next cycle and busy stays low.
// Receive scans the entry memory through its single read port, one entry a
// cycle: busy stays high until a match is found, or for a miss until every
// entry in the table has been compared.
// Disconnect holds busy through S_DISC_WR: the last entry is read at the accepting
// edge, then written into the freed slot. done comes in the first cycle with busy low.
// Reset (rst_n, asynchronous) empties the table and needs no clearing pass.
// The result receiver cannot stall; done is never held back.
`default_nettype none

module udp_socket_demux_table_unit #(
    parameter int SLOTS = udst_pkg::SLOTS_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  mode,
    input  wire logic [31:0] src_ip,
    input  wire logic [31:0] dst_ip,
    input  wire logic [15:0] src_port,
    input  wire logic [15:0] dst_port,
    input  wire logic [15:0] ip_payload_length,
    input  wire logic [31:0] peer_ip,
    input  wire logic [15:0] service_port,
    input  wire logic [5:0]  slot_index,
    output logic             done,
    output logic [2:0]       status,
    output logic [5:0]       slot,
    output logic [15:0]      local_port_wire,
    output logic [15:0]      data_length,
    output logic [5:0]       moved_from,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data
);
    import udst_pkg::*;

`include "udp_socket_demux_table_unit_defines.svh"

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [15:0]        eph_reg, eph_next;
    logic [CNT_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0]   cmp_idx_reg;
    logic               done_reg, done_next;
    logic [2:0]         status_reg, status_next;
    logic [5:0]         slot_reg, slot_next;
    logic [15:0]        lpw_reg, lpw_next;
    logic [15:0]        dlen_reg, dlen_next;
    logic [5:0]         moved_reg, moved_next;
    logic [31:0]        local_ip_reg;

    key_t               key_reg;
    logic [15:0]        plen_reg;
    logic [5:0]         slot_index_reg;

    logic               accept;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_data;
    logic [IDX_W-1:0]   rd_addr;
    entry_t             rd_data;
    match_t             match;
    logic [CNT_W-1:0]   last_cnt;
    logic [15:0]        new_lport;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = !busy;
    assign last_cnt  = count_reg - CNT_W'(1);

    // Scan reads walk the table; otherwise keep the last entry on the port for disconnect.
    assign rd_addr = (state_reg == S_SCAN) ? rd_idx_reg[IDX_W-1:0] : last_cnt[IDX_W-1:0];

    udst_entry_ram #(
        .SLOTS(SLOTS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .key     (key_reg),
        .rd_data (rd_data),
        .match   (match)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            eph_reg      <= FIRST_EPHEMERAL;
            rd_idx_reg   <= '0;
            rd_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
            local_ip_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            eph_reg      <= eph_next;
            rd_idx_reg   <= rd_idx_next;
            rd_valid_reg <= rd_valid_next;
            done_reg     <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                local_ip_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        slot_reg    <= slot_next;
        lpw_reg     <= lpw_next;
        dlen_reg    <= dlen_next;
        moved_reg   <= moved_next;
        cmp_idx_reg <= rd_idx_reg[IDX_W-1:0];
        if (accept)
        begin
            key_reg.src_ip   <= src_ip;
            key_reg.dst_ip   <= dst_ip;
            key_reg.src_port <= src_port;
            key_reg.dst_port <= dst_port;
            plen_reg         <= ip_payload_length;
            slot_index_reg   <= slot_index;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        eph_next      = eph_reg;
        rd_idx_next   = rd_idx_reg;
        rd_valid_next = 1'b0;
        done_next     = 1'b0;
        status_next   = status_reg;
        slot_next     = slot_reg;
        lpw_next      = lpw_reg;
        dlen_next     = dlen_reg;
        moved_next    = moved_reg;
        wr_en         = 1'b0;
        wr_addr       = count_reg[IDX_W-1:0];
        wr_data       = rd_data;
        new_lport     = (mode == MODE_CONNECT) ? swap16(eph_reg) : swap16(service_port);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next = ST_OK;
                    slot_next   = '0;
                    lpw_next    = '0;
                    dlen_next   = '0;
                    moved_next  = '0;
                    case (mode)
                        MODE_RECEIVE:
                        begin
                            if (ip_payload_length < HDR_BYTES)
                            begin
                                status_next = ST_SHORT;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                rd_idx_next = '0;
                                state_next  = S_SCAN;
                            end
                        end
                        MODE_CONNECT, MODE_LISTEN:
                        begin
                            if (count_reg >= CNT_W'(SLOTS))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en               = 1'b1;
                                wr_data.local_port  = new_lport;
                                wr_data.local_ip    = local_ip_reg;
                                if (mode == MODE_CONNECT)
                                begin
                                    wr_data.remote_port = swap16(service_port);
                                    wr_data.remote_ip   = peer_ip;
                                    wr_data.listening   = 1'b0;
                                    eph_next            = eph_reg + 16'd1;
                                end
                                else
                                begin
                                    wr_data.remote_port = '0;
                                    wr_data.remote_ip   = '0;
                                    wr_data.listening   = 1'b1;
                                end
                                count_next = count_reg + CNT_W'(1);
                                slot_next  = SLOT_W'(count_reg);
                                lpw_next   = new_lport;
                            end
                            done_next = 1'b1;
                        end
                        default:
                        begin
                            if (CMP_W'(slot_index) >= CMP_W'(count_reg))
                            begin
                                status_next = ST_BADSLOT;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                // last entry is read at this edge
                                state_next = S_DISC_WR;
                            end
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (rd_idx_reg < count_reg)
                begin
                    rd_valid_next = 1'b1;
                    rd_idx_next   = rd_idx_reg + CNT_W'(1);
                end
                if (rd_valid_reg && (match.listen_hit || match.full_hit))
                begin
                    // bind the sender and drop listening
                    if (match.listen_hit)
                    begin
                        wr_en               = 1'b1;
                        wr_addr             = cmp_idx_reg;
                        wr_data.remote_port = key_reg.src_port;
                        wr_data.remote_ip   = key_reg.src_ip;
                        wr_data.listening   = 1'b0;
                    end
                    status_next   = ST_OK;
                    slot_next     = SLOT_W'(cmp_idx_reg);
                    dlen_next     = plen_reg - HDR_BYTES;
                    done_next     = 1'b1;
                    rd_valid_next = 1'b0;
                    state_next    = S_IDLE;
                end
                else if (!rd_valid_reg && (rd_idx_reg == count_reg))
                begin
                    status_next = ST_NOMATCH;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            S_DISC_WR:
            begin
                wr_en       = 1'b1;
                wr_addr     = IDX_W'(slot_index_reg);
                count_next  = last_cnt;
                status_next = ST_OK;
                slot_next   = slot_index_reg;
                moved_next  = SLOT_W'(last_cnt);
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign done            = done_reg;
    assign status          = status_reg;
    assign slot            = slot_reg;
    assign local_port_wire = lpw_reg;
    assign data_length     = dlen_reg;
    assign moved_from      = moved_reg;

    `UDST_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(SLOTS), "entry count above table size")
    `UDST_ASSERT_IMPL(a_wr_in_range, clk, rst_n, wr_en, CNT_W'(wr_addr) <= count_reg, "write beyond table fill")
    `UDST_ASSERT_IMPL(a_scan_idx, clk, rst_n, state_reg == S_SCAN, rd_idx_reg <= count_reg, "scan index past fill")
    `UDST_ASSERT_IMPL(a_fail_zero, clk, rst_n, done_reg && (status_reg != ST_OK), (slot_reg == '0) && (moved_reg == '0) && (dlen_reg == '0) && (lpw_reg == '0), "failed result carries data")
    `UDST_ASSERT_NEXT(a_connect_grows, clk, rst_n, accept && (mode == MODE_CONNECT) && (count_reg < CNT_W'(SLOTS)), count_reg == $past(count_reg) + CNT_W'(1), "connect did not grow table")

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import udst_pkg::*;

    localparam int NSLOT = SLOTS_DEFAULT;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [15:0] plen;
        logic [31:0] peer_ip;
        logic [15:0] service_port;
        logic [5:0]  slot_index;
    } sock_cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  slot;
        logic [15:0] lport_wire;
        logic [15:0] dlen;
        logic [5:0]  moved_from;
    } sock_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  mode = MODE_RECEIVE;
    logic [31:0] src_ip = '0;
    logic [31:0] dst_ip = '0;
    logic [15:0] src_port = '0;
    logic [15:0] dst_port = '0;
    logic [15:0] ip_payload_length = '0;
    logic [31:0] peer_ip = '0;
    logic [15:0] service_port = '0;
    logic [5:0]  slot_index = '0;
    logic        done;
    logic [2:0]  status;
    logic [5:0]  slot;
    logic [15:0] local_port_wire;
    logic [15:0] data_length;
    logic [5:0]  moved_from;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;

    // Socket table as the testbench sees it, wire byte order throughout.
    logic [15:0] sock_lport [NSLOT];
    logic [31:0] sock_lip [NSLOT];
    logic [15:0] sock_rport [NSLOT];
    logic [31:0] sock_rip [NSLOT];
    logic        sock_listen [NSLOT];
    int          sock_count = 0;
    logic [15:0] ephemeral_port = FIRST_EPHEMERAL;
    logic [31:0] own_ip = '0;

    sock_result_t pending_results[$];
    int           n_errors = 0;
    int           burst_left = 0;

    udp_socket_demux_table_unit uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .mode              (mode),
        .src_ip            (src_ip),
        .dst_ip            (dst_ip),
        .src_port          (src_port),
        .dst_port          (dst_port),
        .ip_payload_length (ip_payload_length),
        .peer_ip           (peer_ip),
        .service_port      (service_port),
        .slot_index        (slot_index),
        .done              (done),
        .status            (status),
        .slot              (slot),
        .local_port_wire   (local_port_wire),
        .data_length       (data_length),
        .moved_from        (moved_from),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [15:0] to_wire(input logic [15:0] v);
        return {v[7:0], v[15:8]};
    endfunction

    // Apply one command to the socket table and return the result it yields.
    function automatic sock_result_t apply_socket_op(input sock_cmd_t c);
        sock_result_t r;
        int           i;
        int           k;
        int           hit;
        logic         local_hit;
        r = '0;
        r.status = ST_NOMATCH;
        hit = -1;
        case (c.mode)
            MODE_RECEIVE:
            begin
                if (c.plen < HDR_BYTES)
                    r.status = ST_SHORT;
                else
                begin
                    for (i = 0; i < sock_count && hit < 0; i++)
                    begin
                        local_hit = sock_lport[i] == c.dst_port && sock_lip[i] == c.dst_ip;
                        if (local_hit && sock_listen[i])
                        begin
                            // bind the sender and stop listening
                            sock_listen[i] = 1'b0;
                            sock_rport[i] = c.src_port;
                            sock_rip[i] = c.src_ip;
                            hit = i;
                        end
                        else if (local_hit && sock_rport[i] == c.src_port &&
                                 sock_rip[i] == c.src_ip)
                            hit = i;
                    end
                    if (hit >= 0)
                    begin
                        r.status = ST_OK;
                        r.slot = 6'(hit);
                        r.dlen = c.plen - HDR_BYTES;
                    end
                end
            end
            MODE_CONNECT, MODE_LISTEN:
            begin
                if (sock_count >= NSLOT)
                    r.status = ST_FULL;
                else
                begin
                    i = sock_count;
                    if (c.mode == MODE_CONNECT)
                    begin
                        sock_lport[i] = to_wire(ephemeral_port);
                        ephemeral_port = ephemeral_port + 16'd1;
                        sock_rport[i] = to_wire(c.service_port);
                        sock_rip[i] = c.peer_ip;
                        sock_listen[i] = 1'b0;
                    end
                    else
                    begin
                        sock_lport[i] = to_wire(c.service_port);
                        sock_rport[i] = '0;
                        sock_rip[i] = '0;
                        sock_listen[i] = 1'b1;
                    end
                    sock_lip[i] = own_ip;
                    sock_count = i + 1;
                    r.status = ST_OK;
                    r.slot = 6'(i);
                    r.lport_wire = sock_lport[i];
                end
            end
            default:
            begin
                if (int'(c.slot_index) >= sock_count)
                    r.status = ST_BADSLOT;
                else
                begin
                    // move the last entry into the freed slot
                    i = sock_count - 1;
                    k = int'(c.slot_index);
                    sock_lport[k] = sock_lport[i];
                    sock_lip[k] = sock_lip[i];
                    sock_rport[k] = sock_rport[i];
                    sock_rip[k] = sock_rip[i];
                    sock_listen[k] = sock_listen[i];
                    sock_count = i;
                    r.status = ST_OK;
                    r.slot = c.slot_index;
                    r.moved_from = 6'(i);
                end
            end
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            n_errors++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        sock_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no pending transaction: status %0d slot %0d",
                       status, slot);
                n_errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(status));
                check_field("slot", 32'(want.slot), 32'(slot));
                check_field("local_port_wire", 32'(want.lport_wire), 32'(local_port_wire));
                check_field("data_length", 32'(want.dlen), 32'(data_length));
                check_field("moved_from", 32'(want.moved_from), 32'(moved_from));
            end
        end
    end

    // Sender pacing: bursts of random length, random gaps between them.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(20, 1);
        case ($urandom_range(7))
            0, 1:    gap = 0;
            2:       gap = $urandom_range(70, 20);
            default: gap = $urandom_range(8, 1);
        endcase
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold start until the transaction is taken; start stays high for the next one unless the pacing adds a gap.
    task automatic issue_op(input sock_cmd_t c);
        mode <= c.mode;
        src_ip <= c.src_ip;
        dst_ip <= c.dst_ip;
        src_port <= c.src_port;
        dst_port <= c.dst_port;
        ip_payload_length <= c.plen;
        peer_ip <= c.peer_ip;
        service_port <= c.service_port;
        slot_index <= c.slot_index;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(apply_socket_op(c));
        pace_sender();
    endtask

    task automatic wait_idle(input int settle);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic set_local_ip(input logic [31:0] v);
        wait_idle(2);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        own_ip = v;
    endtask

    // Unused fields carry random values so every input bit toggles.
    function automatic sock_cmd_t noise_cmd();
        sock_cmd_t c;
        c.mode = 2'($urandom);
        c.src_ip = $urandom;
        c.dst_ip = $urandom;
        c.src_port = 16'($urandom);
        c.dst_port = 16'($urandom);
        c.plen = 16'($urandom);
        c.peer_ip = $urandom;
        c.service_port = 16'($urandom);
        c.slot_index = 6'($urandom);
        return c;
    endfunction

    function automatic sock_cmd_t mk_recv(input logic [31:0] sip, input logic [31:0] dip,
                                          input logic [15:0] sport, input logic [15:0] dport,
                                          input logic [15:0] len);
        sock_cmd_t c;
        c = noise_cmd();
        c.mode = MODE_RECEIVE;
        c.src_ip = sip;
        c.dst_ip = dip;
        c.src_port = sport;
        c.dst_port = dport;
        c.plen = len;
        return c;
    endfunction

    function automatic sock_cmd_t mk_connect(input logic [31:0] peer, input logic [15:0] port);
        sock_cmd_t c;
        c = noise_cmd();
        c.mode = MODE_CONNECT;
        c.peer_ip = peer;
        c.service_port = port;
        return c;
    endfunction

    function automatic sock_cmd_t mk_listen(input logic [15:0] port);
        sock_cmd_t c;
        c = noise_cmd();
        c.mode = MODE_LISTEN;
        c.service_port = port;
        return c;
    endfunction

    function automatic sock_cmd_t mk_disc(input logic [5:0] idx);
        sock_cmd_t c;
        c = noise_cmd();
        c.mode = MODE_DISCONNECT;
        c.slot_index = idx;
        return c;
    endfunction

    function automatic logic [15:0] random_length();
        return ($urandom_range(9) == 0) ? HDR_BYTES : 16'($urandom_range(65535, 8));
    endfunction

    // Datagram addressed to the socket in slot k.
    function automatic sock_cmd_t recv_for(input int k);
        sock_cmd_t c;
        c = mk_recv($urandom, sock_lip[k], 16'($urandom), sock_lport[k], random_length());
        if (!sock_listen[k])
        begin
            c.src_ip = sock_rip[k];
            c.src_port = sock_rport[k];
        end
        return c;
    endfunction

    function automatic sock_cmd_t random_receive();
        sock_cmd_t c;
        int        r;
        int        b;
        r = $urandom_range(99);
        b = $urandom_range(31);
        if (sock_count == 0 || r < 15)
            c = mk_recv($urandom, $urandom, 16'($urandom), 16'($urandom), 16'($urandom));
        else if (r < 25)
            c = mk_recv($urandom, $urandom, 16'($urandom), 16'($urandom),
                        16'($urandom_range(7)));
        else
        begin
            c = recv_for($urandom_range(sock_count - 1));
            // near miss: flip one bit of the 4-tuple
            if (r < 40)
                case ($urandom_range(3))
                    0:       c.src_ip = c.src_ip ^ (32'd1 << b);
                    1:       c.dst_ip = c.dst_ip ^ (32'd1 << b);
                    2:       c.src_port = c.src_port ^ (16'd1 << (b % 16));
                    default: c.dst_port = c.dst_port ^ (16'd1 << (b % 16));
                endcase
        end
        return c;
    endfunction

    function automatic sock_cmd_t random_insert();
        logic [15:0] port;
        port = 16'($urandom);
        if ($urandom_range(1) == 0)
            return mk_connect($urandom, port);
        // reuse a bound local port now and then to get shadowed entries
        if (sock_count > 0 && $urandom_range(2) == 0)
            port = to_wire(sock_lport[$urandom_range(sock_count - 1)]);
        return mk_listen(port);
    endfunction

    function automatic sock_cmd_t random_disconnect();
        if (sock_count > 0 && $urandom_range(99) < 85)
            return mk_disc(6'($urandom_range(sock_count - 1)));
        return mk_disc(6'($urandom));
    endfunction

    task automatic test_directed();
        set_local_ip(32'hFFFF_FFFF);
        issue_op(mk_recv($urandom, $urandom, 16'($urandom), 16'($urandom), 16'd0));
        issue_op(mk_recv($urandom, $urandom, 16'($urandom), 16'($urandom), 16'd7));
        issue_op(mk_recv($urandom, $urandom, 16'($urandom), 16'($urandom), 16'd8));
        issue_op(mk_disc(6'd0));
        issue_op(mk_listen(16'hFFFF));
        issue_op(mk_connect(32'hFFFF_FFFF, 16'h0000));
        issue_op(mk_connect(32'h0000_0000, 16'hFFFF));
        issue_op(mk_listen(16'h1234));
        // first datagram binds the listener, the second matches the full tuple
        issue_op(mk_recv(32'hC0A8_0001, 32'hFFFF_FFFF, 16'hABCD, 16'h3412, 16'd8));
        issue_op(mk_recv(32'hC0A8_0001, 32'hFFFF_FFFF, 16'hABCD, 16'h3412, 16'hFFFF));
        issue_op(mk_recv(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000, 16'h0004, 16'd100));
        issue_op(mk_recv(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0001, 16'h0004, 16'd100));
        issue_op(mk_recv(32'h0000_0000, 32'hFFFF_FFFF, 16'h0000, 16'hFFFF, 16'd9));
        issue_op(mk_recv(32'h0000_0000, 32'h7FFF_FFFF, 16'h0000, 16'hFFFF, 16'd9));
        issue_op(mk_disc(6'd63));
        issue_op(mk_disc(6'd0));
        issue_op(mk_disc(6'(sock_count - 1)));
        issue_op(mk_recv(32'hC0A8_0001, 32'hFFFF_FFFF, 16'hABCD, 16'h3412, 16'd40));
    endtask

    task automatic test_table_full();
        while (sock_count < NSLOT)
            issue_op(random_insert());
        issue_op(mk_connect($urandom, 16'($urandom)));
        issue_op(mk_listen(16'($urandom)));
        issue_op(recv_for(NSLOT - 1));
        issue_op(mk_disc(6'(NSLOT - 1)));
        issue_op(mk_disc(6'(NSLOT - 1)));
        issue_op(mk_disc(6'd0));
    endtask

    task automatic test_random_traffic(input int n_items, input int grow_pct);
        int r;
        repeat (n_items)
        begin
            r = $urandom_range(99);
            if (r < 50)
                issue_op(random_receive());
            else if (r < 50 + grow_pct)
                issue_op(random_insert());
            else
                issue_op(random_disconnect());
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        set_local_ip($urandom);
        test_table_full();
        test_random_traffic(300, 40);
        set_local_ip(32'h0000_0000);
        test_random_traffic(280, 8);
        set_local_ip($urandom);
        test_random_traffic(290, 25);
        wait_idle(NSLOT + 4);
        if (n_errors == 0)
            $display("PASS udp_socket_demux_table_unit");
        else
            $display("FAIL udp_socket_demux_table_unit");
        $finish;
    end

    initial
    begin
        #(20_000_000);
        $display("FAIL udp_socket_demux_table_unit");
        $finish;
    end

endmodule
